// ===== src/swhc_pkg.sv =====
package swhc_pkg;

  localparam int unsigned TS_W       = 31;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned WINDOW_DEF = 300;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // action field codes
  localparam logic ACT_HIT   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REM,
    ST_QUERY,
    ST_DONE
  } state_e;

  // hit write broadcast to every bucket cell
  typedef struct packed {
    logic            en;
    logic [TS_W-1:0] ts;
  } hit_wr_t;

  // query window bounds broadcast to every bucket cell
  typedef struct packed {
    logic            all;   // query time below one window: every bucket counts
    logic [TS_W-1:0] lim;   // bucket counts when its stamp is above this
  } qry_t;

  // running sum handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic [CNT_W-1:0] acc;
  } tok_t;

endpackage

// ===== src/swhc_rem.sv =====
// Remainder by the window length through a reciprocal multiply, in registered
// steps: latch the value, estimate the quotient, subtract quotient times WINDOW.
module swhc_rem import swhc_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [TS_W-1:0]             value_i,
  output logic                        done_o,
  output logic [$clog2(WINDOW)-1:0]   rem_o
);

  localparam int unsigned RW    = $clog2(WINDOW);
  localparam int unsigned ProdW = 2 * TS_W + 1;
  localparam int unsigned Shift = TS_W + RW;
  // ceil(2^(TS_W+RW) / WINDOW): exact quotient for every TS_W-bit value
  localparam longint unsigned MulL =
    ((64'd1 << Shift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [TS_W:0]   MulC  = (TS_W+1)'(MulL);
  localparam logic [TS_W-1:0] WinTs = TS_W'(WINDOW);

  logic             s1_q;
  logic             s2_q;
  logic             done_q;
  logic [TS_W-1:0]  v_q;
  logic [TS_W-1:0]  quo_q, quo_d;
  logic [RW-1:0]    r_q;
  logic [ProdW-1:0] prod;
  logic [TS_W-1:0]  diff;

  always_comb begin
    prod  = ProdW'(v_q) * ProdW'(MulC);
    quo_d = TS_W'(prod >> Shift);
    diff  = v_q - quo_q * WinTs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q   <= 1'b0;
      s2_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_q   <= start_i;
      s2_q   <= s1_q;
      done_q <= s2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= value_i;
    end
    if (s1_q) begin
      quo_q <= quo_d;
    end
    if (s2_q) begin
      r_q <= diff[RW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = r_q;

endmodule

// ===== src/swhc_cell.sv =====
// One bucket: stamp and count, plus one stage of the query sum.
module swhc_cell import swhc_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF,
  parameter int unsigned INDEX  = 0
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hit_wr_t                   wr_i,
  input  logic [$clog2(WINDOW)-1:0] slot_i,
  input  qry_t                      qry_i,
  input  tok_t                      tok_i,
  output tok_t                      tok_o
);

  localparam int unsigned SW = $clog2(WINDOW);
  localparam logic [SW-1:0] IdxC = SW'(INDEX);

  logic [TS_W-1:0]  stamp_q;
  logic [CNT_W-1:0] count_q;
  logic             tok_vld_q;
  logic [CNT_W-1:0] tok_acc_q, tok_acc_d;
  logic [CNT_W-1:0] addend;
  logic [CNT_W:0]   sum;

  always_comb begin
    addend = (qry_i.all || (stamp_q > qry_i.lim)) ? count_q : '0;
    sum    = {1'b0, tok_i.acc} + {1'b0, addend};
    tok_acc_d = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q   <= '0;
      count_q   <= '0;
      tok_vld_q <= 1'b0;
    end else begin
      tok_vld_q <= tok_i.vld;
      if (wr_i.en && (slot_i == IdxC)) begin
        if (stamp_q != wr_i.ts) begin
          stamp_q <= wr_i.ts;
          count_q <= CNT_W'(1);
        end else if (count_q != CNT_MAX) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tok_acc_q <= tok_acc_d;
  end

  assign tok_o = '{vld: tok_vld_q, acc: tok_acc_q};

endmodule

// ===== src/sliding_window_hit_counter.sv =====
// Sliding-window hit counter. WINDOW buckets sit in a row of cells, one
// second each. A hit word (action 0) is reduced modulo WINDOW by a reciprocal
// multiply, and the selected cell then restarts or bumps its count
// (saturating): no new word is taken until that cell is written, and a hit
// gives no result. A query word (action 1) sends a running sum down the row,
// one cell per cycle; each cell adds its count when its stamp is less than
// WINDOW seconds behind the query time, saturating at all ones. A query gives
// one window_hits word once its sum has passed the whole cell row. The result
// sits in an output register, so a new word is taken while it waits; a later
// query's sum is held until that register is free. All buckets are cleared
// by reset, with no clearing pass.
module sliding_window_hit_counter import swhc_pkg::*; #(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              action_i,
  input  logic [TS_W-1:0]   timestamp_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [CNT_W-1:0]  window_hits_o
);

  localparam int unsigned SW = $clog2(WINDOW);
  localparam logic [TS_W-1:0] WinTs = TS_W'(WINDOW);

  state_e state_q, state_d;

  logic             in_acc;
  logic             rem_start;
  logic             rem_done;
  logic [SW-1:0]    rem;
  logic             qry_go;
  logic             res_load;
  logic             out_load;

  logic             launch_q;
  logic             out_vld_q;
  logic [TS_W-1:0]  ts_q;
  logic             all_q;
  logic [TS_W-1:0]  lim_q;
  logic [CNT_W-1:0] res_q;
  logic [CNT_W-1:0] out_q;

  hit_wr_t wr;
  qry_t    qry;
  tok_t    tok [WINDOW+1];

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == ST_IDLE);

  // hit slot = timestamp mod WINDOW
  swhc_rem #(
    .WINDOW (WINDOW)
  ) u_rem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (rem_start),
    .value_i (timestamp_i),
    .done_o  (rem_done),
    .rem_o   (rem)
  );

  assign wr  = '{en: rem_done, ts: ts_q};
  assign qry = '{all: all_q, lim: lim_q};

  // sum enters the row the cycle after the query word, once bounds are held
  assign tok[0] = '{vld: launch_q, acc: '0};

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    swhc_cell #(
      .WINDOW (WINDOW),
      .INDEX  (k)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .slot_i (rem),
      .qry_i  (qry),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );
  end

  always_comb begin
    state_d   = state_q;
    rem_start = 1'b0;
    qry_go    = 1'b0;
    res_load  = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (action_i == ACT_QUERY) begin
            qry_go  = 1'b1;
            state_d = ST_QUERY;
          end else begin
            rem_start = 1'b1;
            state_d   = ST_REM;
          end
        end
      end
      ST_REM: begin
        if (rem_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (tok[WINDOW].vld) begin
          res_load = 1'b1;
          state_d  = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to drain
        if (!out_vld_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      launch_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      launch_q <= qry_go;
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ts_q  <= timestamp_i;
      all_q <= (timestamp_i < WinTs);
      lim_q <= timestamp_i - WinTs;
    end
    if (res_load) begin
      res_q <= tok[WINDOW].acc;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign window_hits_o = out_q;

  // the running sum only leaves the row while a query is outstanding
  a_tail_in_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok[WINDOW].vld |-> (state_q == ST_QUERY))
    else $error("query sum left the cell row outside a query");

  // bucket writes only land while a hit is being resolved
  a_wr_in_rem : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> (state_q == ST_REM))
    else $error("bucket write outside hit handling");

  // a query word always launches a sum into the row next cycle
  a_query_launch : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (action_i == ACT_QUERY)) |=> (launch_q && (state_q == ST_QUERY)))
    else $error("query accepted without launching a sum");

endmodule

// ===== tb/sv/sliding_window_hit_counter_test.sv =====
module sliding_window_hit_counter_test;
  import swhc_pkg::*;

  localparam int unsigned WIN       = WINDOW_DEF;
  localparam int unsigned N_RANDOM  = 1400;
  localparam int unsigned N_CALM    = 200;   // closing stretch with no idling
  localparam logic [TS_W-1:0] TS_TOP = {TS_W{1'b1}};

  // Scoreboard: mirrors the bucket stores and queues the window sums that
  // query words are due to return, oldest first.
  class hit_window_board;
    bit [TS_W-1:0]  stamp [WIN];
    bit [CNT_W-1:0] count [WIN];
    bit [CNT_W-1:0] pending_sums [$];
    int unsigned    hits;
    int unsigned    queries;
    int unsigned    checked;
    int unsigned    errors;

    task report_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Accepted input word: a hit updates its bucket, a query sums the window.
    function void note_word(logic act, logic [TS_W-1:0] ts);
      int unsigned      slot;
      longint unsigned  acc;
      if (act == ACT_HIT) begin
        hits++;
        slot = ts % WIN;
        if (stamp[slot] != ts) begin
          stamp[slot] = ts;
          count[slot] = 1;
        end else if (count[slot] != CNT_MAX) begin
          count[slot] = count[slot] + 1;
        end
      end else begin
        queries++;
        acc = 0;
        for (int k = 0; k < WIN; k++) begin
          // stamps later than the query time count as well
          if (longint'(stamp[k]) + WIN > longint'(ts))
            acc += count[k];
        end
        pending_sums.push_back(acc > CNT_MAX ? CNT_MAX : acc[CNT_W-1:0]);
      end
    endfunction

    task check_result(logic [CNT_W-1:0] got);
      bit [CNT_W-1:0] want;
      if (pending_sums.size() == 0) begin
        report_mismatch($sformatf("window_hits %0d with no query outstanding", got));
      end else begin
        want = pending_sums.pop_front();
        checked++;
        if (got !== want)
          report_mismatch($sformatf("window_hits %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              in_valid_i    = 1'b0;
  logic              in_ready_o;
  logic              action_i      = ACT_HIT;
  logic [TS_W-1:0]   timestamp_i   = '0;
  logic              out_valid_o;
  logic              out_ready_i   = 1'b0;
  logic [CNT_W-1:0]  window_hits_o;

  hit_window_board   sb;
  bit                idle_on = 1'b1;  // random idling on both sides
  int unsigned       rx_stall = 0;

  sliding_window_hit_counter #(
    .WINDOW(WIN)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .timestamp_i  (timestamp_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .window_hits_o(window_hits_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop: well beyond a run of nothing but queries under full stalls.
  initial begin
    #20_000_000;
    $display("Timed out with words still outstanding.");
    $display("== FAIL ==");
    $finish;
  end

  // Offer one word and hold it until taken. Valid stays high straight into
  // the next word unless an idle burst is drawn first.
  task send_word(logic act, logic [TS_W-1:0] ts);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    action_i    <= act;
    timestamp_i <= ts;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_word(act, ts);
  endtask

  // Result side: check each word taken, then draw the next ready level.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i)
      sb.check_result(window_hits_o);
    if (rx_stall != 0) begin
      rx_stall = rx_stall - 1;
      out_ready_i <= 1'b0;
    end else if (idle_on && rst_ni && $urandom_range(0, 7) == 0) begin
      rx_stall = $urandom_range(0, 13);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    int unsigned     pick;
    int unsigned     step;
    logic [TS_W-1:0] cur_ts;
    logic [TS_W-1:0] ts;
    logic            act;

    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    send_word(ACT_QUERY, 31'd1);          // empty window
    send_word(ACT_HIT,   31'd0);          // time zero matches bucket 0 reset stamp
    send_word(ACT_HIT,   31'd0);
    send_word(ACT_QUERY, 31'd0);          // every bucket still inside the window
    send_word(ACT_HIT,   31'd1);
    send_word(ACT_HIT,   31'd1);
    send_word(ACT_HIT,   31'd299);        // last bucket
    send_word(ACT_HIT,   31'd300);        // bucket 0 restarted by a newer second
    send_word(ACT_QUERY, 31'd300);
    send_word(ACT_QUERY, 31'd599);        // stamp 299 falls just out of the window
    send_word(ACT_QUERY, 31'd600);
    send_word(ACT_HIT,   TS_TOP - 31'd1);
    send_word(ACT_HIT,   TS_TOP);         // all timestamp bits set
    send_word(ACT_HIT,   TS_TOP);
    send_word(ACT_QUERY, TS_TOP);
    send_word(ACT_HIT,   31'd5);          // time going backwards: restart bucket
    send_word(ACT_QUERY, 31'd5);          // buckets stamped in the future count too
    send_word(ACT_HIT,   31'd300);        // bucket 0 stamp unchanged: increment
    send_word(ACT_QUERY, 31'd1000);

    // --- random: mostly a rising timeline with bursts in the same second,
    // occasional jumps of about one window, long jumps, and stray stamps ---
    cur_ts = 31'd1;
    for (int i = 0; i < N_RANDOM; i++) begin
      idle_on = (i < N_RANDOM - N_CALM) && ((i / 150) % 3 != 2);
      if (i == N_RANDOM / 2)
        cur_ts = TS_TOP - 31'd2000;       // run the top bit for a while
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        ts = TS_W'($urandom());
      end else begin
        if (pick < 6)       step = $urandom_range(WIN - 2, WIN + 2);
        else if (pick < 8)  step = $urandom_range(1000, 1 << 20);
        else if (pick < 50) step = 0;
        else                step = $urandom_range(1, 3);
        if (TS_TOP - cur_ts < step) cur_ts = TS_W'($urandom_range(1, 1000));
        else                        cur_ts = cur_ts + TS_W'(step);
        ts = cur_ts;
      end
      act = ($urandom_range(0, 99) < 35) ? ACT_QUERY : ACT_HIT;
      send_word(act, ts);
    end
    in_valid_i <= 1'b0;
    idle_on = 1'b0;

    // drain, then allow one full query pass for anything stray
    while (sb.pending_sums.size() != 0) @(posedge clk_i);
    repeat (WIN + 8) @(posedge clk_i);

    $display("Sent %0d hit and %0d query words across bucket restarts, window edges,",
             sb.hits, sb.queries);
    $display("top-bit stamps and backward time; %0d sums compared, %0d mismatches.",
             sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
